### rtl/core/fmd_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the FM
// discriminator with bit clock recovery. No dependencies.
`default_nettype none
package fmd_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int PHASE_BITS   = 32;
    localparam int DC_SHIFT     = 10;
    localparam int CORDIC_STEPS = 16;

    localparam int REG_BITS   = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = 2 * SAMPLE_BITS + 1;
    localparam int XW         = PROD_W + 3;
    localparam int ZW         = 34;
    localparam int K_W        = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W = 5;
    localparam int FM_SHIFT   = 32 - SAMPLE_BITS;
    localparam int DC_W       = SAMPLE_BITS + DC_SHIFT;
    localparam int PH_SHIFT   = 2;
    localparam int STEP_SHIFT = 10;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd2;

    localparam logic [REG_BITS-1:0] NOMINAL_RST = 31'd107374182;
    localparam logic [REG_BITS-1:0] MIN_RST     = 31'd37580964;
    localparam logic [REG_BITS-1:0] MAX_RST     = 31'd322122547;

    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(1 << 30);
    localparam logic signed [ZW-1:0] Z_RND     = ZW'(1 << (FM_SHIFT - 1));
    localparam logic signed [ZW-1:0] FM_HI     = ZW'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [PHASE_BITS:0]  PH_HALF   = (PHASE_BITS + 1)'(1) << (PHASE_BITS - 1);

    typedef struct packed {
        logic signed [PROD_W-1:0] di;
        logic signed [PROD_W-1:0] dq;
    } t_prod;

    typedef struct packed {
        logic  push;
        t_prod prod;
    } t_prod_wr;

    typedef struct packed {
        logic  avail;
        t_prod prod;
    } t_prod_rd;

    // atan(2^-k), pi = 2^31
    function automatic logic signed [ZW-1:0] fmd_atan(input logic [ATAN_IDX_W-1:0] k);
        logic signed [ZW-1:0] v;
        case (k)
            5'd0:  v = ZW'(536870912);
            5'd1:  v = ZW'(316933406);
            5'd2:  v = ZW'(167458907);
            5'd3:  v = ZW'(85004756);
            5'd4:  v = ZW'(42667331);
            5'd5:  v = ZW'(21354465);
            5'd6:  v = ZW'(10679838);
            5'd7:  v = ZW'(5340245);
            5'd8:  v = ZW'(2670163);
            5'd9:  v = ZW'(1335087);
            5'd10: v = ZW'(667544);
            5'd11: v = ZW'(333772);
            5'd12: v = ZW'(166886);
            5'd13: v = ZW'(83443);
            5'd14: v = ZW'(41722);
            5'd15: v = ZW'(20861);
            5'd16: v = ZW'(10430);
            5'd17: v = ZW'(5215);
            5'd18: v = ZW'(2608);
            5'd19: v = ZW'(1304);
            5'd20: v = ZW'(652);
            5'd21: v = ZW'(326);
            5'd22: v = ZW'(163);
            5'd23: v = ZW'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/core/fm_discriminator_bit_clock_recovery.sv
// Top level of the FM discriminator with PLL bit clock recovery.
// Depends on fmd_pkg, fmd_front, fmd_queue and fmd_back.
//
//   channel   direction  handshake           payload
//   sample    in         i_push / o_full     i_i_sample, i_q_sample
//   result    out        i_pop / o_empty     o_bit_value, o_tracked_step
//   config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// Front end: accept, 4 shared-multiplier steps, push.
// Back end: load, 16 CORDIC iterations, fm, DC, PLL, clamp, phase advance;
// the CORDIC loop sets the sustained rate.
// A two-entry product queue lets the front take the next item while the back works.
// Reset is synchronous; no clearing pass.
// The back end holds in its advance step if a bit is due while a result is untaken.
`default_nettype none
module fm_discriminator_bit_clock_recovery
    import fmd_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output      logic                          o_full,
    input  wire logic signed [SAMPLE_BITS-1:0] i_i_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_q_sample,
    output      logic                          o_empty,
    input  wire logic                          i_pop,
    output      logic                          o_bit_value,
    output      logic [REG_BITS-1:0]           o_tracked_step,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [REG_BITS-1:0]           i_cfg_data
);

    t_prod_wr q_wr;
    t_prod_rd q_rd;
    logic     q_full;
    logic     q_pop;

    fmd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_i_sample (i_i_sample),
        .i_q_sample (i_q_sample),
        .o_wr       (q_wr),
        .i_q_full   (q_full)
    );

    fmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    fmd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_rd           (q_rd),
        .o_q_pop        (q_pop),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_bit_value    (o_bit_value),
        .o_tracked_step (o_tracked_step)
    );

endmodule
`default_nettype wire

### rtl/core/fmd_front.sv
// Front end: takes one IQ sample per item and forms the conjugate product
// with the previous sample on one shared multiplier. Depends on fmd_pkg.
`default_nettype none
module fmd_front
    import fmd_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output      logic                          o_full,
    input  wire logic signed [SAMPLE_BITS-1:0] i_i_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_q_sample,
    output      t_prod_wr                      o_wr,
    input  wire logic                          i_q_full
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_PUSH} t_state;

    localparam logic [1:0] MUL_II = 2'd0;
    localparam logic [1:0] MUL_QQ = 2'd1;
    localparam logic [1:0] MUL_QI = 2'd2;
    localparam logic [1:0] MUL_IQ = 2'd3;

    t_state                        r_state;
    logic [1:0]                    r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_cur_i, r_cur_q, r_last_i, r_last_q;
    logic signed [PROD_W-1:0]      r_acc_i, r_acc_q;

    logic signed [SAMPLE_BITS-1:0]   mul_a, mul_b;
    logic signed [2*SAMPLE_BITS-1:0] mul_p;
    logic signed [PROD_W-1:0]        mul_x;

    always_comb begin
        mul_a = (r_cnt == MUL_II || r_cnt == MUL_IQ) ? r_cur_i : r_cur_q;
        mul_b = (r_cnt == MUL_II || r_cnt == MUL_QI) ? r_last_i : r_last_q;
        mul_p = mul_a * mul_b;
        mul_x = PROD_W'(mul_p);
    end

    assign o_full       = (r_state != ST_IDLE);
    assign o_wr.push    = (r_state == ST_PUSH) && !i_q_full;
    assign o_wr.prod.di = r_acc_i;
    assign o_wr.prod.dq = r_acc_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= MUL_II;
            r_last_i <= '0;
            r_last_q <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_push) begin
                        r_cur_i <= i_i_sample;
                        r_cur_q <= i_q_sample;
                        r_cnt   <= MUL_II;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    case (r_cnt)
                        MUL_II:  r_acc_i <= mul_x;
                        MUL_QQ:  r_acc_i <= r_acc_i + mul_x;
                        MUL_QI:  r_acc_q <= mul_x;
                        default: r_acc_q <= r_acc_q - mul_x;
                    endcase
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == MUL_IQ) begin
                        r_last_i <= r_cur_i;
                        r_last_q <= r_cur_q;
                        r_state  <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> (r_state == ST_MUL && r_cnt == MUL_II))
        else $error("accepted item did not start the product");
    a_mul_ends_in_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_cnt == MUL_IQ) |=> (r_state == ST_PUSH))
        else $error("product finished without a push");
`endif

endmodule
`default_nettype wire

### rtl/core/fmd_queue.sv
// Short queue of conjugate products between the front and back ends.
// Depends on fmd_pkg.
`default_nettype none
module fmd_queue
    import fmd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_prod_wr i_wr,
    output      logic     o_full,
    input  wire logic     i_pop,
    output      t_prod_rd o_rd
);

    t_prod              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_pop;

    assign o_full     = (r_cnt == QCNT_W'(QDEPTH));
    assign o_rd.avail = (r_cnt != '0);
    assign o_rd.prod  = r_mem[r_rd_ptr];
    assign do_pop     = i_pop && o_rd.avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr.push) begin
                r_mem[r_wr_ptr] <= i_wr.prod;
                r_wr_ptr        <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_wr.push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_wr.push && do_pop) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr.push)
        else $error("push into a full product queue");
`endif

endmodule
`default_nettype wire

### rtl/core/fmd_back.sv
// Back end: iterative CORDIC angle, DC removal, bit-timing PLL and the
// result register; holds the step registers. Depends on fmd_pkg.
`default_nettype none
module fmd_back
    import fmd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [REG_BITS-1:0]   i_cfg_data,
    input  wire t_prod_rd              i_rd,
    output      logic                  o_q_pop,
    output      logic                  o_empty,
    input  wire logic                  i_pop,
    output      logic                  o_bit_value,
    output      logic [REG_BITS-1:0]   o_tracked_step
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ITER, ST_FM, ST_DC, ST_PLL, ST_CLAMP, ST_ADV
    } t_state;

    localparam int STW = PHASE_BITS + 1;

    t_state                        r_state;
    logic [K_W-1:0]                r_k;
    logic signed [XW-1:0]          r_x, r_y;
    logic signed [ZW-1:0]          r_z;
    logic                          r_zero;
    logic signed [SAMPLE_BITS-1:0] r_fm, r_last_fm;
    logic signed [DC_W-1:0]        r_dc;
    logic                          r_cross, r_bit;
    logic [PHASE_BITS-1:0]         r_phase;
    logic signed [STW-1:0]         r_st;
    logic [REG_BITS-1:0]           r_step, r_min, r_max;
    logic                          r_out_valid, r_out_bit;
    logic [REG_BITS-1:0]           r_out_step;

    // pre-rotation
    logic signed [XW-1:0] ld_di, ld_dq, ld_x, ld_y;
    logic signed [ZW-1:0] ld_z;
    // iteration
    logic signed [XW-1:0] it_xs, it_ys;
    logic signed [ZW-1:0] it_atan;
    // fm
    logic signed [ZW-1:0]          fm_r, fm_w;
    logic signed [SAMPLE_BITS-1:0] fm_v;
    // dc
    logic signed [DC_W:0]   dc_w;
    logic signed [DC_W-1:0] dc_n, fine_cur, fine_prev;
    logic                   cur_pos, prev_pos;
    // pll
    logic signed [STW-1:0]  err, err_ph, err_st;
    logic                   lt_min, gt_max;
    logic [REG_BITS-1:0]    clamped;
    logic [PHASE_BITS:0]    sum;
    logic                   out_free;

    always_comb begin
        ld_di = XW'(i_rd.prod.di);
        ld_dq = XW'(i_rd.prod.dq);
        ld_x  = ld_di;
        ld_y  = ld_dq;
        ld_z  = '0;
        if (ld_di < 0) begin
            if (ld_dq >= 0) begin
                ld_x = ld_dq;
                ld_y = -ld_di;
                ld_z = Z_QUARTER;
            end else begin
                ld_x = -ld_dq;
                ld_y = ld_di;
                ld_z = -Z_QUARTER;
            end
        end

        it_xs   = r_x >>> r_k;
        it_ys   = r_y >>> r_k;
        it_atan = fmd_atan(ATAN_IDX_W'(r_k));

        fm_r = r_zero ? '0 : r_z + Z_RND;
        fm_w = fm_r >>> FM_SHIFT;
        if (fm_w > FM_HI) begin
            fm_v = SAMPLE_BITS'(FM_HI);
        end else if (fm_w < ~FM_HI) begin
            fm_v = SAMPLE_BITS'(~FM_HI);
        end else begin
            fm_v = SAMPLE_BITS'(fm_w);
        end

        dc_w      = (DC_W + 1)'(r_dc) + (DC_W + 1)'(r_fm) - (DC_W + 1)'(r_dc >>> DC_SHIFT);
        dc_n      = dc_w[DC_W-1:0];
        fine_cur  = $signed({r_fm, {DC_SHIFT{1'b0}}});
        fine_prev = $signed({r_last_fm, {DC_SHIFT{1'b0}}});
        cur_pos   = fine_cur >= dc_n;
        prev_pos  = fine_prev >= dc_n;

        err    = $signed({1'b0, r_phase} - PH_HALF);
        err_ph = err >>> PH_SHIFT;
        err_st = err >>> STEP_SHIFT;

        lt_min = r_st < $signed(STW'(r_min));
        gt_max = r_st > $signed(STW'(r_max));
        if (gt_max || (lt_min && (r_min > r_max))) begin
            clamped = r_max;
        end else if (lt_min) begin
            clamped = r_min;
        end else begin
            clamped = r_st[REG_BITS-1:0];
        end

        sum      = {1'b0, r_phase} + STW'(r_step);
        out_free = !r_out_valid || i_pop;
    end

    assign o_q_pop        = (r_state == ST_IDLE) && i_rd.avail;
    assign o_empty        = !r_out_valid;
    assign o_bit_value    = r_out_bit;
    assign o_tracked_step = r_out_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_min       <= MIN_RST;
            r_max       <= MAX_RST;
            r_step      <= NOMINAL_RST;
            r_phase     <= '0;
            r_dc        <= '0;
            r_last_fm   <= '0;
        end else begin
            if (r_out_valid && i_pop && !(r_state == ST_ADV && sum[PHASE_BITS])) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_rd.avail) begin
                        r_x     <= ld_x;
                        r_y     <= ld_y;
                        r_z     <= ld_z;
                        r_zero  <= (ld_di == 0) && (ld_dq == 0);
                        r_k     <= '0;
                        r_state <= ST_ITER;
                    end
                end
                ST_ITER: begin
                    if (!r_y[XW-1]) begin
                        r_x <= r_x + it_ys;
                        r_y <= r_y - it_xs;
                        r_z <= r_z + it_atan;
                    end else begin
                        r_x <= r_x - it_ys;
                        r_y <= r_y + it_xs;
                        r_z <= r_z - it_atan;
                    end
                    r_k <= r_k + K_W'(1);
                    if (r_k == K_W'(CORDIC_STEPS - 1)) begin
                        r_state <= ST_FM;
                    end
                end
                ST_FM: begin
                    r_fm    <= fm_v;
                    r_state <= ST_DC;
                end
                ST_DC: begin
                    r_dc      <= dc_n;
                    r_cross   <= cur_pos != prev_pos;
                    r_bit     <= cur_pos;
                    r_last_fm <= r_fm;
                    r_state   <= ST_PLL;
                end
                ST_PLL: begin
                    if (r_cross) begin
                        r_phase <= r_phase - err_ph[PHASE_BITS-1:0];
                        r_st    <= $signed(STW'(r_step)) - err_st;
                    end else begin
                        r_st    <= $signed(STW'(r_step));
                    end
                    r_state <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    if (r_cross) begin
                        r_step <= clamped;
                    end
                    r_state <= ST_ADV;
                end
                ST_ADV: begin
                    if (!sum[PHASE_BITS]) begin
                        r_phase <= sum[PHASE_BITS-1:0];
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_phase     <= sum[PHASE_BITS-1:0];
                        r_out_valid <= 1'b1;
                        r_out_bit   <= r_bit;
                        r_out_step  <= r_step;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NOMINAL: r_step <= i_cfg_data;
                    CFG_MIN:     r_min  <= i_cfg_data;
                    CFG_MAX:     r_max  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTH
    a_result_from_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_ADV))
        else $error("result loaded outside the phase advance");
    a_pop_starts_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == ST_ITER && r_k == '0))
        else $error("queue pop did not start the CORDIC");
`endif

endmodule
`default_nettype wire
